// ===== rtl/tats_pkg.sv =====
// Shared widths, codes, reset values and types for the adaptive transfer-size block.
package tats_pkg;

	localparam int SIZE_W     = 31;
	localparam int THR_W      = 32;
	localparam int BYTES_W    = 32;
	localparam int MS_W       = 32;
	localparam int SPEED_W    = 42;
	localparam int DIFF_W     = 43;
	localparam int CHG_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SCALE_W    = 10;
	// |bytes_moved| * 1000 stays below 2^41
	localparam int MAG_W      = 41;

	localparam int WINDOW_DEF = 8;

	localparam logic [SCALE_W-1:0] MS_SCALE = 10'd1000;

	localparam logic OP_RESTART = 1'b0;
	localparam logic OP_SAMPLE  = 1'b1;

	localparam logic [CHG_W-1:0] CHG_NONE   = 2'd0;
	localparam logic [CHG_W-1:0] CHG_GREW   = 2'd1;
	localparam logic [CHG_W-1:0] CHG_SHRANK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SIZE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UP_THRESHOLD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_THRESHOLD = 3'd4;

	localparam logic [SIZE_W-1:0] INITIAL_SIZE_RST   = 31'd4194304;
	localparam logic [SIZE_W-1:0] STEP_SIZE_RST      = 31'd1048576;
	localparam logic [SIZE_W-1:0] MAX_SIZE_RST       = 31'd67108864;
	localparam logic [THR_W-1:0]  UP_THRESHOLD_RST   = 32'd1000;
	localparam logic [THR_W-1:0]  DOWN_THRESHOLD_RST = 32'd1000000;

	typedef struct packed {
		logic busy;
		logic done;
		logic rem_nz;
	} div_status_t;

endpackage

// ===== rtl/tats_if.sv =====
// Handshake channel interfaces: configuration writes, samples in, results out.
interface tats_cfg_if;
	import tats_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;
	modport source(output valid, reg_index, wdata, input ready);
	modport sink(input valid, reg_index, wdata, output ready);
endinterface

interface tats_sample_if;
	import tats_pkg::*;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic signed [BYTES_W-1:0] bytes_moved;
	logic [MS_W-1:0]           elapsed_ms;
	modport source(output valid, opcode, bytes_moved, elapsed_ms, input ready);
	modport sink(input valid, opcode, bytes_moved, elapsed_ms, output ready);
endinterface

interface tats_result_if;
	import tats_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [SIZE_W-1:0]         request_size;
	logic signed [SPEED_W-1:0] speed;
	logic [CHG_W-1:0]          size_change;
	modport source(output valid, request_size, speed, size_change, input ready);
	modport sink(input valid, request_size, speed, size_change, output ready);
endinterface

// ===== rtl/throughput_adaptive_transfer_size.sv =====
// Top level: adapts the transfer request size from measured throughput.
//
//  channel   modport  payload                                   role
//  cfg       sink     reg_index, wdata                          register writes, always ready
//  sample    sink     opcode, bytes_moved, elapsed_ms           restart or transfer sample
//  result    source   request_size, speed, size_change          one per accepted transaction
//
// A sample runs the multiply, load, divide, subtract, add, threshold, decide and finish
// steps; the divide step is the serial divider forming bytes*1000/ms, one quotient bit a cycle.
// A restart goes straight to the finish step. Ready stays low while a transaction is in work.
// A finished result waits in the output register; the next transaction runs meanwhile and
// holds only at its last step until the output register is free.
// Reset (arst_n low) loads the register defaults and clears the speed history.
module throughput_adaptive_transfer_size #(
	parameter int WINDOW = tats_pkg::WINDOW_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	tats_cfg_if.sink        cfg,
	tats_sample_if.sink     sample,
	tats_result_if.source   result
);
	import tats_pkg::*;

	localparam int SLOTS  = WINDOW - 1;
	localparam int CNT_W  = $clog2(WINDOW);
	localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SUM_W  = DIFF_W + $clog2(WINDOW);
	localparam int CMP_W  = SUM_W + 1;
	localparam int PROD_W = THR_W + CNT_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_LOAD = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_SUB  = 4'd4;
	localparam logic [3:0] ST_ADD  = 4'd5;
	localparam logic [3:0] ST_THR  = 4'd6;
	localparam logic [3:0] ST_DEC  = 4'd7;
	localparam logic [3:0] ST_FIN  = 4'd8;

	logic [3:0]                state_q;

	logic [SIZE_W-1:0]         init_size_q;
	logic [SIZE_W-1:0]         step_q;
	logic [SIZE_W-1:0]         max_q;
	logic [THR_W-1:0]          up_thr_q;
	logic [THR_W-1:0]          dn_thr_q;

	logic [SIZE_W-1:0]         cur_size_q;
	logic signed [SPEED_W-1:0] prev_speed_q;
	logic                      have_prev_q;
	logic [CNT_W-1:0]          diff_count_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic [AW-1:0]             head_q;

	logic                      neg_q;
	logic [BYTES_W-1:0]        mag_abs_q;
	logic [MS_W-1:0]           ms_q;
	logic [MAG_W-1:0]          prod_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [DIFF_W-1:0]  diff_q;
	logic [PROD_W-1:0]         up_prod_q;
	logic [PROD_W-1:0]         dn_prod_q;
	logic [SIZE_W:0]           grow_sum_q;
	logic [CHG_W-1:0]          change_q;

	logic                      out_valid_q;
	logic [SIZE_W-1:0]         out_size_q;
	logic signed [SPEED_W-1:0] out_speed_q;
	logic [CHG_W-1:0]          out_chg_q;

	logic                      in_fire;
	logic                      out_free;
	logic                      div_start;
	logic [MAG_W-1:0]          div_quo;
	div_status_t               div_st;
	logic [SPEED_W-1:0]        quo_x;
	logic [DIFF_W-1:0]         old_diff;
	logic                      ram_we;
	logic signed [CMP_W-1:0]   sum_x;
	logic signed [CMP_W-1:0]   up_x;
	logic signed [CMP_W-1:0]   dn_x;
	logic                      up_hit;
	logic                      dn_hit;
	logic [AW-1:0]             head_next;

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == ST_IDLE);
	assign in_fire      = sample.valid && sample.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign div_start    = (state_q == ST_LOAD);
	assign ram_we       = (state_q == ST_ADD) && have_prev_q;
	assign quo_x        = {1'b0, div_quo};

	assign sum_x  = CMP_W'(sum_q);
	assign up_x   = $signed(CMP_W'(up_prod_q));
	assign dn_x   = -$signed(CMP_W'(dn_prod_q));
	assign up_hit = (diff_count_q != '0) && (sum_x > up_x);
	assign dn_hit = (diff_count_q != '0) && (sum_x < dn_x);

	assign head_next = (head_q == AW'(SLOTS - 1)) ? '0 : head_q + 1'b1;

	tats_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (ms_q),
		.quotient (div_quo),
		.status   (div_st)
	);

	// read and write addresses both sit on the head, which advances in the add step
	tats_ram #(
		.WIDTH (DIFF_W),
		.DEPTH (SLOTS)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (diff_q),
		.raddr (head_q),
		.rdata (old_diff)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_size_q <= INITIAL_SIZE_RST;
			step_q      <= STEP_SIZE_RST;
			max_q       <= MAX_SIZE_RST;
			up_thr_q    <= UP_THRESHOLD_RST;
			dn_thr_q    <= DOWN_THRESHOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.reg_index)
				REG_INITIAL_SIZE:   init_size_q <= cfg.wdata[SIZE_W-1:0];
				REG_STEP_SIZE:      step_q      <= cfg.wdata[SIZE_W-1:0];
				REG_MAX_SIZE:       max_q       <= cfg.wdata[SIZE_W-1:0];
				REG_UP_THRESHOLD:   up_thr_q    <= cfg.wdata[THR_W-1:0];
				REG_DOWN_THRESHOLD: dn_thr_q    <= cfg.wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and history state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_size_q   <= INITIAL_SIZE_RST;
			prev_speed_q <= '0;
			have_prev_q  <= 1'b0;
			diff_count_q <= '0;
			sum_q        <= '0;
			head_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && !(state_q == ST_FIN && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (sample.opcode == OP_RESTART) begin
							cur_size_q <= init_size_q;
							state_q    <= ST_FIN;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL:  state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					// drop the oldest difference once the window is full
					if (have_prev_q && diff_count_q == CNT_W'(SLOTS)) begin
						sum_q <= sum_q - SUM_W'($signed(old_diff));
					end
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					if (have_prev_q) begin
						sum_q  <= sum_q + SUM_W'(diff_q);
						head_q <= head_next;
						if (diff_count_q != CNT_W'(SLOTS)) begin
							diff_count_q <= diff_count_q + 1'b1;
						end
					end
					prev_speed_q <= speed_q;
					have_prev_q  <= 1'b1;
					state_q      <= ST_THR;
				end
				ST_THR: state_q <= ST_DEC;
				ST_DEC: begin
					if (up_hit) begin
						if (grow_sum_q < {1'b0, max_q}) begin
							cur_size_q <= grow_sum_q[SIZE_W-1:0];
						end
					end else if (dn_hit) begin
						if (cur_size_q > step_q) begin
							cur_size_q <= cur_size_q - step_q;
						end
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-transaction datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					neg_q     <= sample.bytes_moved[BYTES_W-1];
					mag_abs_q <= sample.bytes_moved[BYTES_W-1] ?
						BYTES_W'(-sample.bytes_moved) : BYTES_W'(sample.bytes_moved);
					ms_q      <= (sample.elapsed_ms == '0) ? MS_W'(1) : sample.elapsed_ms;
					speed_q   <= '0;
					change_q  <= CHG_NONE;
				end
			end
			ST_MUL: begin
				prod_q <= MAG_W'({{SCALE_W{1'b0}}, mag_abs_q}
					* {{BYTES_W{1'b0}}, MS_SCALE});
			end
			ST_DIV: begin
				// floor of a negative quotient: -q, or -q-1 with a remainder left
				if (div_st.done) begin
					if (!neg_q) begin
						speed_q <= $signed(quo_x);
					end else if (div_st.rem_nz) begin
						speed_q <= $signed(~quo_x);
					end else begin
						speed_q <= $signed(-quo_x);
					end
				end
			end
			ST_SUB: begin
				diff_q <= DIFF_W'(speed_q) - DIFF_W'(prev_speed_q);
			end
			ST_THR: begin
				up_prod_q  <= PROD_W'({{CNT_W{1'b0}}, up_thr_q}
					* {{THR_W{1'b0}}, diff_count_q});
				dn_prod_q  <= PROD_W'({{CNT_W{1'b0}}, dn_thr_q}
					* {{THR_W{1'b0}}, diff_count_q});
				grow_sum_q <= {1'b0, cur_size_q} + {1'b0, step_q};
			end
			ST_DEC: begin
				if (up_hit) begin
					change_q <= (grow_sum_q < {1'b0, max_q}) ? CHG_GREW : CHG_NONE;
				end else if (dn_hit) begin
					change_q <= (cur_size_q > step_q) ? CHG_SHRANK : CHG_NONE;
				end else begin
					change_q <= CHG_NONE;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_size_q  <= cur_size_q;
					out_speed_q <= speed_q;
					out_chg_q   <= change_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.request_size = out_size_q;
	assign result.speed        = out_speed_q;
	assign result.size_change  = out_chg_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		diff_count_q <= CNT_W'(SLOTS))
		else $error("difference count beyond window");
	a_no_prev_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!have_prev_q |-> diff_count_q == '0)
		else $error("differences recorded before first sample");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide step");
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> !div_st.busy)
		else $error("ready while divider busy");
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> result.valid)
		else $error("finished transaction not presented");
`endif
endmodule

// ===== rtl/tats_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tats_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/tats_div.sv =====
// Restoring serial divider: one quotient bit per cycle, unsigned operands.
module tats_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tats_pkg::MAG_W-1:0]  dividend,
	input  logic [tats_pkg::MS_W-1:0]   divisor,
	output logic [tats_pkg::MAG_W-1:0]  quotient,
	output tats_pkg::div_status_t       status
);
	import tats_pkg::*;

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [MS_W:0]      rem_q;
	logic [MAG_W-1:0]   quo_q;
	logic [MS_W-1:0]    dvs_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MS_W:0]      trial;
	logic [MS_W+1:0]    sub;
	logic               take;

	// partial remainder stays below the divisor, so its top bit is free
	assign trial = {rem_q[MS_W-1:0], quo_q[MAG_W-1]};
	assign sub   = {1'b0, trial} - {2'b00, dvs_q};
	assign take  = ~sub[MS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(MAG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? sub[MS_W:0] : trial;
			quo_q <= {quo_q[MAG_W-2:0], take};
		end
	end

	assign quotient = quo_q;
	assign status   = '{busy: busy_q, done: done_q, rem_nz: |rem_q};

`ifndef SYNTHESIS
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider not busy after start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with empty count");
`endif
endmodule
